// ===== hw/rtl/wrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// wrtc_pkg
// Shared types, codes and reset constants for the Wiegand receiver timing
// checker.
// ----------------------------------------------------------------------------
package wrtc_pkg;

   localparam int MAX_BITS_DEFAULT = 64;
   localparam int TIMER_W          = 16;
   localparam int TIMER_BITS       = 16;
   localparam int FRAME_W          = 64;
   localparam int LEN_W            = 7;
   localparam int INDEX_W          = 6;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 16;

   localparam logic [TIMER_W-1:0] ELAPSED_MASK =
      TIMER_W'((33'(1) << TIMER_BITS) - 33'(1));

   typedef logic [TIMER_W-1:0] timer_type;

   typedef enum logic [1:0] {
      KIND_DATA0 = 2'd0,
      KIND_DATA1 = 2'd1,
      KIND_TIMER = 2'd2,
      KIND_ARM   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      LINE_NONE  = 2'd0,
      LINE_DATA0 = 2'd1,
      LINE_DATA1 = 2'd2
   } line_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_D0_CONFLICT = 3'd1,
      STATUS_D1_CONFLICT = 3'd2,
      STATUS_ORDER       = 3'd3,
      STATUS_GAP_TIMEOUT = 3'd4,
      STATUS_PULSE_WIDTH = 3'd5
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_LENGTH    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONTINUOUS_MODE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_NOMINAL   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_TOLERANCE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAP_NOMINAL     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAP_TOLERANCE   = 3'd5;

   localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET    = 7'd26;
   localparam timer_type        PULSE_NOMINAL_RESET   = 16'd50;
   localparam timer_type        PULSE_TOLERANCE_RESET = 16'd5;
   localparam timer_type        GAP_NOMINAL_RESET     = 16'd1950;
   localparam timer_type        GAP_TOLERANCE_RESET   = 16'd10;

   typedef struct packed {
      status_type           status;
      logic [FRAME_W-1:0]   frame_value;
      logic [LEN_W-1:0]     bits_received;
      logic [INDEX_W-1:0]   error_index;
      timer_type            error_time;
   } rsp_type;

endpackage

// ===== hw/rtl/wrtc_window_check.sv =====
// ----------------------------------------------------------------------------
// wrtc_window_check
// Flags a measured time outside nominal +/- tolerance. Bounds are formed one
// bit wider so they never wrap; a negative lower bound means no lower bound.
// ----------------------------------------------------------------------------
module wrtc_window_check (
   input  wrtc_pkg::timer_type measured,
   input  wrtc_pkg::timer_type nominal,
   input  wrtc_pkg::timer_type tolerance,
   output logic                out_of_window
);
   import wrtc_pkg::*;

   logic [TIMER_W:0] upper_bound;
   logic [TIMER_W:0] measured_plus_tol;

   assign upper_bound       = {1'b0, nominal} + {1'b0, tolerance};
   assign measured_plus_tol = {1'b0, measured} + {1'b0, tolerance};

   assign out_of_window = ({1'b0, measured} > upper_bound) ||
                          (measured_plus_tol < {1'b0, nominal});

endmodule

// ===== hw/rtl/wiegand_receiver_timing_checker_core.sv =====
// ----------------------------------------------------------------------------
// wiegand_receiver_timing_checker_core
// Wiegand frame receiver with pulse-width and inter-bit gap checks.
// ----------------------------------------------------------------------------
// The req channel carries line events: tuser is the kind (data0 edge, data1
// edge, timer expiry, arm) and tdata the edge direction and the timer counts
// since the previous edge. An arm beat starts a frame; a falling edge opens a
// pulse, the matching rising edge closes it and shifts in the bit. The rsp
// channel gives one beat per finished frame or error: tuser is the status,
// tdata the received bits, bit count and the first bad pulse or gap.
// The csr port writes the six setup registers at any edge with csr_we high.
// One beat is taken per clock while req_tready is high. An event goes into
// an input register, is handled by one pass of compare and shift logic,
// and a result lands in the output register.
// When rsp_tready is low the result holds, the input register keeps the next
// beat and req_tready drops until the result is taken.
// Reset returns the setup registers to their defaults and leaves the block
// disarmed with an empty frame.
// ----------------------------------------------------------------------------
module wiegand_receiver_timing_checker_core #(
   parameter int MAX_BITS = wrtc_pkg::MAX_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: rising [0], elapsed [16:1], zero fill [23:17]
   input  logic [23:0]                          req_tdata,
   // req_tuser: kind [1:0]
   input  logic [1:0]                           req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: frame_value [63:0], bits_received [70:64],
   //            error_index [76:71], error_time [92:77], zero fill [95:93]
   output logic [95:0]                          rsp_tdata,
   // rsp_tuser: status [2:0]
   output logic [2:0]                           rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [wrtc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [wrtc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import wrtc_pkg::*;

   localparam int CNT_W = $clog2(MAX_BITS + 1);

   // setup registers
   logic [LEN_W-1:0] frame_length_ff;
   logic             continuous_mode_ff;
   timer_type        pulse_nominal_ff;
   timer_type        pulse_tolerance_ff;
   timer_type        gap_nominal_ff;
   timer_type        gap_tolerance_ff;

   // input stage
   logic             in_valid_ff;
   kind_type         in_kind_ff;
   logic             in_rising_ff;
   timer_type        in_elapsed_ff;

   // frame state
   logic                armed_ff,             armed_in;
   line_type            open_line_ff,         open_line_in;
   logic                gap_running_ff,       gap_running_in;
   logic [CNT_W-1:0]    bit_count_ff,         bit_count_in;
   logic [MAX_BITS-1:0] bit_shift_ff,         bit_shift_in;
   logic                pulse_fault_seen_ff,  pulse_fault_seen_in;
   logic [INDEX_W-1:0]  pulse_fault_index_ff, pulse_fault_index_in;
   timer_type           pulse_fault_time_ff,  pulse_fault_time_in;
   logic                gap_fault_seen_ff,    gap_fault_seen_in;
   logic [INDEX_W-1:0]  gap_fault_index_ff,   gap_fault_index_in;
   timer_type           gap_fault_time_ff,    gap_fault_time_in;

   // output stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type result;
   logic    emit;

   logic       advance;
   logic       check_pulse;
   timer_type  win_nominal;
   timer_type  win_tolerance;
   logic       out_of_window;
   line_type   event_line;
   logic [LEN_W-1:0] eff_length;
   logic [LEN_W-1:0] count_ext;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff    <= FRAME_LENGTH_RESET;
         continuous_mode_ff <= 1'b0;
         pulse_nominal_ff   <= PULSE_NOMINAL_RESET;
         pulse_tolerance_ff <= PULSE_TOLERANCE_RESET;
         gap_nominal_ff     <= GAP_NOMINAL_RESET;
         gap_tolerance_ff   <= GAP_TOLERANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_LENGTH:    frame_length_ff    <= csr_wdata[LEN_W-1:0];
            CSR_CONTINUOUS_MODE: continuous_mode_ff <= csr_wdata[0];
            CSR_PULSE_NOMINAL:   pulse_nominal_ff   <= csr_wdata;
            CSR_PULSE_TOLERANCE: pulse_tolerance_ff <= csr_wdata;
            CSR_GAP_NOMINAL:     gap_nominal_ff     <= csr_wdata;
            CSR_GAP_TOLERANCE:   gap_tolerance_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_kind_ff    <= kind_type'(req_tuser);
         in_rising_ff  <= req_tdata[0];
         in_elapsed_ff <= req_tdata[16:1] & ELAPSED_MASK;
      end
   end

   // pulse width is checked on pulse end, the gap on pulse start
   assign check_pulse   = (open_line_ff != LINE_NONE);
   assign win_nominal   = check_pulse ? pulse_nominal_ff   : gap_nominal_ff;
   assign win_tolerance = check_pulse ? pulse_tolerance_ff : gap_tolerance_ff;

   wrtc_window_check u_window (
      .measured      (in_elapsed_ff),
      .nominal       (win_nominal),
      .tolerance     (win_tolerance),
      .out_of_window (out_of_window)
   );

   assign event_line = line_type'({in_kind_ff[0], !in_kind_ff[0]});
   assign count_ext  = LEN_W'(bit_count_ff);

   always_comb begin
      if (frame_length_ff == '0) begin
         eff_length = LEN_W'(1);
      end else if (frame_length_ff > LEN_W'(MAX_BITS)) begin
         eff_length = LEN_W'(MAX_BITS);
      end else begin
         eff_length = frame_length_ff;
      end
   end

   always_comb begin
      armed_in             = armed_ff;
      open_line_in         = open_line_ff;
      gap_running_in       = gap_running_ff;
      bit_count_in         = bit_count_ff;
      bit_shift_in         = bit_shift_ff;
      pulse_fault_seen_in  = pulse_fault_seen_ff;
      pulse_fault_index_in = pulse_fault_index_ff;
      pulse_fault_time_in  = pulse_fault_time_ff;
      gap_fault_seen_in    = gap_fault_seen_ff;
      gap_fault_index_in   = gap_fault_index_ff;
      gap_fault_time_in    = gap_fault_time_ff;
      emit                 = 1'b0;
      result.status        = STATUS_OK;
      result.error_index   = '0;
      result.error_time    = '0;

      if (in_kind_ff == KIND_ARM) begin
         armed_in           = 1'b1;
         open_line_in       = LINE_NONE;
         gap_running_in     = 1'b0;
         bit_count_in       = '0;
         bit_shift_in       = '0;
         pulse_fault_seen_in = 1'b0;
         gap_fault_seen_in  = 1'b0;
      end else if (armed_ff) begin
         if (in_kind_ff == KIND_TIMER) begin
            if (gap_running_ff && bit_count_ff != '0) begin
               emit               = 1'b1;
               result.status      = STATUS_GAP_TIMEOUT;
               result.error_index = INDEX_W'(count_ext - LEN_W'(1));
            end
         end else if (open_line_ff != LINE_NONE && open_line_ff != event_line) begin
            emit          = 1'b1;
            result.status = (in_kind_ff == KIND_DATA0) ? STATUS_D0_CONFLICT
                                                       : STATUS_D1_CONFLICT;
         end else if (open_line_ff == LINE_NONE) begin
            if (in_rising_ff) begin
               emit          = 1'b1;
               result.status = STATUS_ORDER;
            end else begin
               if (gap_running_ff && bit_count_ff != '0 && !gap_fault_seen_ff &&
                   out_of_window) begin
                  gap_fault_seen_in  = 1'b1;
                  gap_fault_index_in = INDEX_W'(count_ext - LEN_W'(1));
                  gap_fault_time_in  = in_elapsed_ff;
               end
               gap_running_in = 1'b0;
               open_line_in   = event_line;
            end
         end else if (!in_rising_ff) begin
            emit          = 1'b1;
            result.status = STATUS_ORDER;
         end else begin
            if (!pulse_fault_seen_ff && out_of_window) begin
               pulse_fault_seen_in  = 1'b1;
               pulse_fault_index_in = INDEX_W'(count_ext);
               pulse_fault_time_in  = in_elapsed_ff;
            end
            bit_shift_in = MAX_BITS'({bit_shift_ff, in_kind_ff[0]});
            if (bit_count_ff < CNT_W'(MAX_BITS)) begin
               bit_count_in = bit_count_ff + CNT_W'(1);
            end
            open_line_in   = LINE_NONE;
            gap_running_in = 1'b1;
            if (LEN_W'(bit_count_in) >= eff_length) begin
               emit = 1'b1;
               if (gap_fault_seen_in) begin
                  result.status      = STATUS_GAP_TIMEOUT;
                  result.error_index = gap_fault_index_in;
                  result.error_time  = gap_fault_time_in;
               end else if (pulse_fault_seen_in) begin
                  result.status      = STATUS_PULSE_WIDTH;
                  result.error_index = pulse_fault_index_in;
                  result.error_time  = pulse_fault_time_in;
               end
            end
         end
      end

      result.frame_value   = FRAME_W'(bit_shift_in);
      result.bits_received = LEN_W'(bit_count_in);

      // drop the frame after any result; stay armed only on a clean frame
      if (emit) begin
         armed_in            = (result.status == STATUS_OK) && continuous_mode_ff;
         open_line_in        = LINE_NONE;
         gap_running_in      = 1'b0;
         bit_count_in        = '0;
         bit_shift_in        = '0;
         pulse_fault_seen_in = 1'b0;
         gap_fault_seen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff            <= 1'b0;
         open_line_ff        <= LINE_NONE;
         gap_running_ff      <= 1'b0;
         bit_count_ff        <= '0;
         bit_shift_ff        <= '0;
         pulse_fault_seen_ff <= 1'b0;
         gap_fault_seen_ff   <= 1'b0;
      end else if (advance) begin
         armed_ff            <= armed_in;
         open_line_ff        <= open_line_in;
         gap_running_ff      <= gap_running_in;
         bit_count_ff        <= bit_count_in;
         bit_shift_ff        <= bit_shift_in;
         pulse_fault_seen_ff <= pulse_fault_seen_in;
         gap_fault_seen_ff   <= gap_fault_seen_in;
      end
      if (advance) begin
         pulse_fault_index_ff <= pulse_fault_index_in;
         pulse_fault_time_ff  <= pulse_fault_time_in;
         gap_fault_index_ff   <= gap_fault_index_in;
         gap_fault_time_ff    <= gap_fault_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000, rsp_ff.error_time, rsp_ff.error_index,
                        rsp_ff.bits_received, rsp_ff.frame_value};

   a_error_disarms : assert property (@(posedge clock) disable iff (reset)
      (advance && emit && result.status != STATUS_OK) |=> !armed_ff)
      else $error("block still armed after an error result");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= CNT_W'(MAX_BITS))
      else $error("bit count beyond maximum frame size");

   a_gap_no_pulse : assert property (@(posedge clock) disable iff (reset)
      gap_running_ff |-> (open_line_ff == LINE_NONE))
      else $error("gap running while a pulse is open");

   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_elapsed_ff)))
      else $error("stalled input beat lost");

endmodule
